// File: src/scbm_pkg.sv
// shared types, constants and budget table for the stage cycle budget monitor
// no dependencies

package scbm_pkg;

    localparam int STAGES_DEF     = 9;
    localparam int CYCLE_BITS_DEF = 32;
    localparam int SUM_W          = 64;
    localparam int CNT_W          = 32;
    localparam int AVG_W          = 32;
    localparam int STAGE_W        = 4;
    localparam int BUDGET_W       = 9;

    typedef struct packed {
        logic [STAGE_W-1:0] stage;
        logic [31:0]        cycles;
    } t_cmd;

    typedef struct packed {
        logic             rejected;
        logic [AVG_W-1:0] stage_average;
        logic             stage_over_budget;
        logic             all_within_budget;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCUM,
        S_DIV
    } t_state;

    // fixed per-stage budget, stages past the ninth get zero
    function automatic logic [BUDGET_W-1:0] stage_budget(input logic [STAGE_W-1:0] stage);
        logic [BUDGET_W-1:0] b;
        case (stage)
            4'd0:    b = 9'd3;
            4'd1:    b = 9'd3;
            4'd2:    b = 9'd5;
            4'd3:    b = 9'd5;
            4'd4:    b = 9'd30;
            4'd5:    b = 9'd450;
            4'd6:    b = 9'd2;
            4'd7:    b = 9'd1;
            4'd8:    b = 9'd1;
            default: b = 9'd0;
        endcase
        return b;
    endfunction

endpackage

// File: src/stage_cycle_budget_monitor.sv
// top level of the stage cycle budget monitor: per-stage sums and counts,
// sequencer and flag logic; depends on scbm_pkg and scbm_div
//
//  channel  | signals                 | handshake
//  ---------+-------------------------+-------------------------------------
//  command  | start, busy, i_cmd      | transfer when start high, busy low
//  result   | o_valid, o_result       | one-cycle strobe, no back-pressure
//
// a valid stage runs from the accepting edge to the result strobe through an
// accumulate step, the bit-serial divider (one quotient bit per cycle over the
// 64-bit sum) and a compare and flag update
// a rejected stage gives its result in the cycle after the transfer, busy stays low
// synchronous active-low reset clears all sums, counts and flags
// the result side cannot stall; each result is shown for exactly one cycle

module stage_cycle_budget_monitor
    import scbm_pkg::*;
#(
    parameter int STAGES     = STAGES_DEF,
    parameter int CYCLE_BITS = CYCLE_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    localparam int IDX_W   = (STAGES > 1) ? $clog2(STAGES) : 1;
    // only the low measured bits of cycles take part
    localparam int CYC_USE = (CYCLE_BITS < 32) ? CYCLE_BITS : 32;

    t_state             r_state, n_state;
    logic [SUM_W-1:0]   r_sum   [STAGES];
    logic [SUM_W-1:0]   n_sum   [STAGES];
    logic [CNT_W-1:0]   r_count [STAGES];
    logic [CNT_W-1:0]   n_count [STAGES];
    logic [STAGES-1:0]  r_flags, n_flags;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [SUM_W-1:0]   r_cyc, n_cyc;
    logic               r_valid, n_valid;
    t_result            r_result, n_result;

    logic               accept;
    logic               bad_stage;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   sum_new;
    logic [CNT_W-1:0]   cnt_new;
    logic               div_go;
    logic               div_done;
    logic [SUM_W-1:0]   quotient;
    logic               over;

    assign accept    = start && !busy;
    assign bad_stage = {1'b0, i_cmd.stage} >= (STAGE_W + 1)'(STAGES);

    // saturating accumulate on the selected stage
    always_comb begin
        sum_ext = {1'b0, r_sum[r_idx]} + {1'b0, r_cyc};
        sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        cnt_new = (&r_count[r_idx]) ? r_count[r_idx] : r_count[r_idx] + 1'b1;
    end

    // compare uses the full quotient, the reported average is saturated
    assign over = quotient > SUM_W'(stage_budget(STAGE_W'(r_idx)));

    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_count  = r_count;
        n_flags  = r_flags;
        n_idx    = r_idx;
        n_cyc    = r_cyc;
        n_valid  = 1'b0;
        n_result = r_result;
        div_go   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (bad_stage) begin
                        // state untouched, flags reported as they stand
                        n_valid                    = 1'b1;
                        n_result.rejected          = 1'b1;
                        n_result.stage_average     = '0;
                        n_result.stage_over_budget = 1'b0;
                        n_result.all_within_budget = (r_flags == '0);
                    end else begin
                        n_idx   = i_cmd.stage[IDX_W-1:0];
                        n_cyc   = SUM_W'(i_cmd.cycles[CYC_USE-1:0]);
                        n_state = S_ACCUM;
                    end
                end
            end
            S_ACCUM: begin
                n_sum[r_idx]   = sum_new;
                n_count[r_idx] = cnt_new;
                div_go         = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_flags[r_idx]             = over;
                    n_valid                    = 1'b1;
                    n_result.rejected          = 1'b0;
                    n_result.stage_average     = (quotient[SUM_W-1:AVG_W] != '0) ? '1
                                                 : quotient[AVG_W-1:0];
                    n_result.stage_over_budget = over;
                    n_result.all_within_budget = (n_flags == '0);
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flags <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < STAGES; i++) begin
                r_sum[i]   <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
            r_valid <= n_valid;
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cyc    <= n_cyc;
        r_result <= n_result;
    end

    // divisor is the updated count, never zero
    scbm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (sum_new),
        .i_divisor  (cnt_new),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: src/scbm_div.sv
// restoring divider, sum by count, one quotient bit per cycle
// depends on scbm_pkg

module scbm_div
    import scbm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_run;
    logic              r_done;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              q_bit;

    // borrow out of the trial subtract means the divisor did not fit
    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, r_div};
        q_bit = !diff[CNT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(SUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_run) begin
            // remainder stays below the divisor, so its low bits are enough
            r_rem <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: src/scbm_chk.sv
// port-level checks for the stage cycle budget monitor, bound to the top level
// depends on scbm_pkg

module scbm_chk
    import scbm_pkg::*;
#(
    parameter int STAGES = STAGES_DEF
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_cmd    i_cmd,
    input logic    busy,
    input logic    o_valid,
    input t_result o_result
);

    logic xfer_ok;
    logic xfer_bad;

    assign xfer_ok  = start && !busy && ({1'b0, i_cmd.stage} < (STAGE_W + 1)'(STAGES));
    assign xfer_bad = start && !busy && ({1'b0, i_cmd.stage} >= (STAGE_W + 1)'(STAGES));

    a_ok_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_ok |=> busy && !o_valid)
        else $error("valid stage transfer did not start work");

    a_bad_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_bad |=> o_valid && o_result.rejected && !busy)
        else $error("rejected stage not answered next cycle");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.rejected |->
            o_result.stage_average == '0 && !o_result.stage_over_budget)
        else $error("rejected result carries data");

    a_measured_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.rejected |-> !busy && $past(busy))
        else $error("measured result outside of a busy period");

    a_over_not_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.stage_over_budget |-> !o_result.all_within_budget)
        else $error("over-budget stage reported with all within budget");

endmodule

bind stage_cycle_budget_monitor scbm_chk #(.STAGES(STAGES)) u_scbm_chk (.*);

// File: test/tb.sv
// self-checking testbench for the stage cycle budget monitor
// depends on scbm_pkg and stage_cycle_budget_monitor; needs no files or arguments

`timescale 1ns / 1ps

module tb;
    import scbm_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_CMDS  = 650;
    localparam int WIDE_CMDS    = 50;
    // the drain after the last result leaves room for stray strobes
    localparam int DRAIN_CYCLES = 80;
    // a generous bound for about 725 transfers at their slowest
    localparam int CYCLE_LIMIT  = 1000000;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    // shadow copy of the per-stage accounting
    logic [SUM_W-1:0]        stage_sum   [STAGES_DEF];
    logic [CNT_W-1:0]        stage_count [STAGES_DEF];
    logic [STAGES_DEF-1:0]   over_flags;
    int unsigned             budget_limit [STAGES_DEF] = '{3, 3, 5, 5, 30, 450, 2, 1, 1};

    t_cmd    pending_cmds[$];
    t_result expected_results[$];

    int total_cmds  = 0;
    int transfers   = 0;
    int n_results   = 0;
    int n_rejected  = 0;
    int n_over      = 0;
    int n_all_clear = 0;
    int fail_count  = 0;
    int cycle_count = 0;

    stage_cycle_budget_monitor u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // accumulate one sample, refresh the average and the stage's flag, or reject an out-of-range stage
    function automatic t_result average_against_budget(t_cmd cmd);
        t_result          r;
        int unsigned      s;
        logic [SUM_W-1:0] add;
        logic [SUM_W-1:0] quot;
        r = '0;
        if (cmd.stage >= STAGES_DEF) begin
            // out-of-range stage: nothing moves, flags still reported
            r.rejected          = 1'b1;
            r.all_within_budget = (over_flags == '0);
            return r;
        end
        s   = cmd.stage;
        add = {32'b0, cmd.cycles};
        // sum and count hold at all-ones instead of wrapping
        if (stage_sum[s] > ~add)
            stage_sum[s] = '1;
        else
            stage_sum[s] = stage_sum[s] + add;
        if (stage_count[s] != '1)
            stage_count[s] = stage_count[s] + 1'b1;
        quot = stage_sum[s] / {32'b0, stage_count[s]};
        // compare on the full quotient, report it clipped to 32 bits
        over_flags[s]       = (quot > budget_limit[s]);
        r.stage_average     = (quot > 64'hFFFF_FFFF) ? '1 : quot[AVG_W-1:0];
        r.stage_over_budget = over_flags[s];
        r.all_within_budget = (over_flags == '0);
        return r;
    endfunction

    function automatic t_cmd make_cmd(int unsigned stage, logic [31:0] cycles);
        t_cmd c;
        c.stage  = stage[STAGE_W-1:0];
        c.cycles = cycles;
        return c;
    endfunction

    // mostly valid stages with samples around the budget, so flags keep toggling;
    // wide mode mixes in counts of up to full width that pin averages high for good
    function automatic t_cmd random_cmd(bit wide);
        t_cmd        c;
        int unsigned b;
        if ($urandom_range(0, 99) < 12)
            c.stage = STAGE_W'($urandom_range(STAGES_DEF, 15));
        else
            c.stage = STAGE_W'($urandom_range(0, STAGES_DEF - 1));
        if (c.stage >= STAGES_DEF) begin
            c.cycles = $urandom;
        end else if (wide) begin
            c.cycles = $urandom >> $urandom_range(0, 31);
        end else begin
            b        = budget_limit[c.stage];
            c.cycles = $urandom_range(0, 2 * b + 1);
        end
        return c;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // stimulus: directed opening, budget-centered random items, wide tail
    initial begin
        for (int s = 0; s < STAGES_DEF; s++) begin
            stage_sum[s]   = '0;
            stage_count[s] = '0;
        end
        over_flags = '0;

        // right at budget, just over, then pulled back under
        pending_cmds.push_back(make_cmd(0, 3));
        pending_cmds.push_back(make_cmd(0, 5));
        pending_cmds.push_back(make_cmd(9, 0));
        pending_cmds.push_back(make_cmd(0, 0));
        pending_cmds.push_back(make_cmd(1, 4));
        pending_cmds.push_back(make_cmd(1, 2));
        pending_cmds.push_back(make_cmd(2, 6));
        pending_cmds.push_back(make_cmd(3, 5));
        pending_cmds.push_back(make_cmd(4, 31));
        pending_cmds.push_back(make_cmd(5, 450));
        pending_cmds.push_back(make_cmd(5, 452));
        pending_cmds.push_back(make_cmd(15, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(5, 448));
        pending_cmds.push_back(make_cmd(6, 2));
        pending_cmds.push_back(make_cmd(7, 1));
        pending_cmds.push_back(make_cmd(8, 2));
        pending_cmds.push_back(make_cmd(12, 32'hAAAA_AAAA));
        pending_cmds.push_back(make_cmd(8, 0));
        pending_cmds.push_back(make_cmd(10, 32'h5555_5555));
        pending_cmds.push_back(make_cmd(4, 0));

        for (int k = 0; k < RANDOM_CMDS; k++)
            pending_cmds.push_back(random_cmd(1'b0));

        // full-width samples last, since they leave those stages over budget
        pending_cmds.push_back(make_cmd(8, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(0, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(5, 32'h8000_0000));
        pending_cmds.push_back(make_cmd(4, 32'h7FFF_FFFF));
        pending_cmds.push_back(make_cmd(5, 0));
        for (int k = 0; k < WIDE_CMDS; k++)
            pending_cmds.push_back(random_cmd(1'b1));
        total_cmds = pending_cmds.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked: %0d rejected, %0d over budget",
                 transfers, n_results, n_rejected, n_over);
        $display("%0d results with every stage within budget, %0d mismatches",
                 n_all_clear, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("stage_cycle_budget_monitor test passed");
        end else begin
            $display("stage_cycle_budget_monitor test failed");
        end
        $finish;
    end

    // command driver: a transfer happens at an edge where start is high and busy low;
    // the expectation is formed at that edge, in transfer order
    always @(posedge i_clk) begin : cmd_driver
        int idle_pct;
        // sender gaps: 38 in a hundred, then 84, then back to back
        if (transfers < total_cmds / 3)
            idle_pct = 38;
        else if (transfers < 2 * total_cmds / 3)
            idle_pct = 84;
        else
            idle_pct = 0;

        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(average_against_budget(pending_cmds.pop_front()));
                transfers++;
            end
            if (start && busy) begin
                // request stays up with the same command until the block takes it
            end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                start <= 1'b1;
                i_cmd <= pending_cmds[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result monitor: every strobe is taken, no back-pressure exists
    always @(posedge i_clk) begin : result_monitor
        t_result exp_res;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result strobe with no command outstanding: %0h", o_result);
                fail_count++;
            end else begin
                exp_res = expected_results.pop_front();
                check_field("rejected", exp_res.rejected, o_result.rejected);
                check_field("stage_average", exp_res.stage_average, o_result.stage_average);
                check_field("stage_over_budget", exp_res.stage_over_budget,
                            o_result.stage_over_budget);
                check_field("all_within_budget", exp_res.all_within_budget,
                            o_result.all_within_budget);
                n_results++;
                n_rejected  += exp_res.rejected;
                n_over      += exp_res.stage_over_budget;
                n_all_clear += exp_res.all_within_budget;
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("stage_cycle_budget_monitor test failed");
            $finish;
        end
    end

endmodule

// File: files.f
src/scbm_pkg.sv
src/scbm_div.sv
src/stage_cycle_budget_monitor.sv
src/scbm_chk.sv
test/tb.sv
